// ===== sv/tpcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcf_pkg
// shared constants and types for the three point circle fit
// ----------------------------------------------------------------------------
package tpcf_pkg;
	localparam int COORD_BITS = 11;
	localparam int FRAC_BITS  = 4;
	localparam int OUT_BITS = 21;
	localparam int NUM_BITS = 64;
	localparam int DET_BITS = 36;
	localparam int QUO_BITS = 48;
	localparam int SQ_BITS  = 44;
	localparam int RAD_BITS = 22;
	localparam logic signed [OUT_BITS-1:0] CENTER_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
	localparam logic signed [OUT_BITS-1:0] CENTER_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

	// side information carried alongside the divider
	typedef struct packed {
		logic                     valid;
		logic                     coll;
		logic signed [24:0]       x1f;
		logic signed [24:0]       y1f;
	} div_tag_t;

	// side information carried alongside the root extractor
	typedef struct packed {
		logic                     valid;
		logic                     coll;
		logic                     clip;
		logic signed [OUT_BITS-1:0] ccol;
		logic signed [OUT_BITS-1:0] crow;
	} rt_tag_t;
endpackage

// ===== sv/tpcf_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcf_div_cell
// one restoring division step on magnitudes, two quotients side by side
// ----------------------------------------------------------------------------
module tpcf_div_cell import tpcf_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [NUM_BITS-1:0]  rem_a_in,
	input  logic [NUM_BITS-1:0]  rem_b_in,
	input  logic [QUO_BITS-1:0]  quo_a_in,
	input  logic [QUO_BITS-1:0]  quo_b_in,
	input  logic [DET_BITS-1:0]  dvs_in,
	input  logic [1:0]           neg_in,
	input  div_tag_t             tag_in,
	output logic [NUM_BITS-1:0]  rem_a_out,
	output logic [NUM_BITS-1:0]  rem_b_out,
	output logic [QUO_BITS-1:0]  quo_a_out,
	output logic [QUO_BITS-1:0]  quo_b_out,
	output logic [DET_BITS-1:0]  dvs_out,
	output logic [1:0]           neg_out,
	output div_tag_t             tag_out
);
	localparam int SH = QUO_BITS - 1 - STEP;
	logic [NUM_BITS+QUO_BITS-1:0] dsh;
	logic [NUM_BITS+QUO_BITS-1:0] ra, rb;
	logic                         ta, tb;

	always_comb begin
		dsh = {{NUM_BITS{1'b0}}, {(QUO_BITS-DET_BITS){1'b0}}, dvs_in} << SH;
		ra  = {{QUO_BITS{1'b0}}, rem_a_in};
		rb  = {{QUO_BITS{1'b0}}, rem_b_in};
		ta  = (ra >= dsh);
		tb  = (rb >= dsh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_a_out     <= ta ? NUM_BITS'(ra - dsh) : rem_a_in;
			rem_b_out     <= tb ? NUM_BITS'(rb - dsh) : rem_b_in;
			quo_a_out     <= quo_a_in | (QUO_BITS'(ta) << SH);
			quo_b_out     <= quo_b_in | (QUO_BITS'(tb) << SH);
			dvs_out       <= dvs_in;
			neg_out       <= neg_in;
		end
	end
endmodule

// ===== sv/tpcf_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcf_sqrt_cell
// one bit of a trial-square (restoring style) integer square root
// ----------------------------------------------------------------------------
module tpcf_sqrt_cell import tpcf_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [SQ_BITS-1:0]  val_in,
	input  logic [RAD_BITS-1:0] root_in,
	input  rt_tag_t             tag_in,
	output logic [SQ_BITS-1:0]  val_out,
	output logic [RAD_BITS-1:0] root_out,
	output rt_tag_t             tag_out
);
	localparam int B = RAD_BITS - 1 - STEP;
	logic [RAD_BITS-1:0] trial;
	logic [SQ_BITS+1:0]  tsq;
	logic                take;

	always_comb begin
		trial = root_in | (RAD_BITS'(1) << B);
		tsq   = (SQ_BITS+2)'(trial) * (SQ_BITS+2)'(trial);
		take  = (tsq <= (SQ_BITS+2)'(val_in));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else if (en) begin
			tag_out <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_out      <= val_in;
			root_out     <= take ? trial : root_in;
		end
	end
endmodule

// ===== sv/three_point_circle_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_point_circle_fit
// circumcircle of three pixel points, centre and radius in fixed point
// ----------------------------------------------------------------------------
// channel | signals                                      | direction
// in      | in_valid, in_stall, first_x .. third_y       | upstream to block
// out     | out_valid, out_stall, centre, radius, flags  | block to downstream
//
// one transfer per cycle sustained while the output is not stalled; the pipeline is
// 4 front stages, 48 division cells, 2 clamp/square stages, 22 root cells
// and the output register, 77 register stages from input to output
// the whole pipe advances together; out_stall with out_valid high freezes every stage
// in_stall is high only while the output is held full and stalled
// reset clears the stage valid flags and the tags that travel with them
// ----------------------------------------------------------------------------
module three_point_circle_fit import tpcf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [COORD_BITS-1:0]      first_x,
	input  logic [COORD_BITS-1:0]      first_y,
	input  logic [COORD_BITS-1:0]      second_x,
	input  logic [COORD_BITS-1:0]      second_y,
	input  logic [COORD_BITS-1:0]      third_x,
	input  logic [COORD_BITS-1:0]      third_y,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [OUT_BITS-1:0] center_col,
	output logic signed [OUT_BITS-1:0] center_row,
	output logic [OUT_BITS-1:0]        circle_radius,
	output logic                       collinear,
	output logic                       clipped
);
	// pipeline advances whenever the output register can take a transfer
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---- stage 1: edge vectors and differences of squared norms
	logic               v_s1;
	logic signed [17:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [24:0] x1f_s1, y1f_s1;
	logic signed [34:0] s2_s1, s3_s1;
	logic signed [17:0] x1, y1, x2, y2, x3, y3;

	always_comb begin
		x1 = 18'(first_x);  y1 = 18'(first_y);
		x2 = 18'(second_x); y2 = 18'(second_y);
		x3 = 18'(third_x);  y3 = 18'(third_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= x2 - x1;
			ay_s1  <= y2 - y1;
			bx_s1  <= x3 - x1;
			by_s1  <= y3 - y1;
			// |p|^2 - |p1|^2 = d.(p + p1)
			s2_s1  <= 35'((x2 - x1) * (x2 + x1)) + 35'((y2 - y1) * (y2 + y1));
			s3_s1  <= 35'((x3 - x1) * (x3 + x1)) + 35'((y3 - y1) * (y3 + y1));
			x1f_s1 <= 25'(x1) <<< FRAC_BITS;
			y1f_s1 <= 25'(y1) <<< FRAC_BITS;
		end
	end

	// ---- stage 2: cross products, one multiply each
	logic               v_s2;
	logic signed [35:0] p_ab_s2, p_ba_s2;
	logic signed [53:0] n1_s2, n2_s2, n3_s2, n4_s2;
	logic signed [24:0] x1f_s2, y1f_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_ab_s2 <= 36'(ax_s1 * by_s1);
			p_ba_s2 <= 36'(bx_s1 * ay_s1);
			n1_s2   <= 54'(s2_s1 * by_s1);
			n2_s2   <= 54'(s3_s1 * ay_s1);
			n3_s2   <= 54'(s3_s1 * ax_s1);
			n4_s2   <= 54'(s2_s1 * bx_s1);
			x1f_s2  <= x1f_s1;
			y1f_s2  <= y1f_s1;
		end
	end

	// ---- stage 3: determinant and numerators
	logic               v_s3;
	logic signed [DET_BITS-1:0] det_s3;
	logic signed [NUM_BITS-1:0] ncol_s3, nrow_s3;
	logic signed [24:0] x1f_s3, y1f_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3  <= (p_ab_s2 - p_ba_s2) <<< 1;
			ncol_s3 <= (NUM_BITS'(n1_s2) - NUM_BITS'(n2_s2)) <<< FRAC_BITS;
			nrow_s3 <= (NUM_BITS'(n3_s2) - NUM_BITS'(n4_s2)) <<< FRAC_BITS;
			x1f_s3  <= x1f_s2;
			y1f_s3  <= y1f_s2;
		end
	end

	// ---- stage 4: magnitudes and signs for the divider
	div_tag_t            dtag [0:QUO_BITS];
	logic [NUM_BITS-1:0] rem_a [0:QUO_BITS];
	logic [NUM_BITS-1:0] rem_b [0:QUO_BITS];
	logic [QUO_BITS-1:0] quo_a [0:QUO_BITS];
	logic [QUO_BITS-1:0] quo_b [0:QUO_BITS];
	logic [DET_BITS-1:0] dvs   [0:QUO_BITS];
	logic [1:0]          neg   [0:QUO_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dtag[0] <= '0;
		else if (en) dtag[0] <= '{valid: v_s3, coll: (det_s3 == '0),
		                          x1f: x1f_s3, y1f: y1f_s3};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_a[0]     <= ncol_s3[NUM_BITS-1] ? NUM_BITS'(-ncol_s3) : ncol_s3;
			rem_b[0]     <= nrow_s3[NUM_BITS-1] ? NUM_BITS'(-nrow_s3) : nrow_s3;
			quo_a[0]     <= '0;
			quo_b[0]     <= '0;
			// zero divisor on collinear input: force one so the cells stay sane
			dvs[0]       <= (det_s3 == '0) ? DET_BITS'(1) :
			                (det_s3[DET_BITS-1] ? DET_BITS'(-det_s3) : det_s3);
			neg[0]       <= {nrow_s3[NUM_BITS-1] ^ det_s3[DET_BITS-1],
			                 ncol_s3[NUM_BITS-1] ^ det_s3[DET_BITS-1]};
		end
	end

	// chain of division cells, one quotient bit each
	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		tpcf_div_cell #(.STEP(i)) u_cell (
			.clk, .arst_n, .en,
			.rem_a_in(rem_a[i]), .rem_b_in(rem_b[i]),
			.quo_a_in(quo_a[i]), .quo_b_in(quo_b[i]),
			.dvs_in(dvs[i]), .neg_in(neg[i]), .tag_in(dtag[i]),
			.rem_a_out(rem_a[i+1]), .rem_b_out(rem_b[i+1]),
			.quo_a_out(quo_a[i+1]), .quo_b_out(quo_b[i+1]),
			.dvs_out(dvs[i+1]), .neg_out(neg[i+1]), .tag_out(dtag[i+1])
		);
	end

	// ---- clamp stage: signed quotients saturated to the output range
	logic               v_c1, coll_c1, clip_c1;
	logic signed [OUT_BITS-1:0] ccol_c1, crow_c1;
	logic signed [24:0] x1f_c1, y1f_c1;
	logic signed [QUO_BITS:0] qa, qb;
	logic ca, cb;
	logic signed [OUT_BITS-1:0] sa, sb;

	always_comb begin
		qa = neg[QUO_BITS][0] ? -$signed({1'b0, quo_a[QUO_BITS]}) : $signed({1'b0, quo_a[QUO_BITS]});
		qb = neg[QUO_BITS][1] ? -$signed({1'b0, quo_b[QUO_BITS]}) : $signed({1'b0, quo_b[QUO_BITS]});
		ca = 1'b1; cb = 1'b1;
		if (qa > (QUO_BITS+1)'(CENTER_MAX))      sa = CENTER_MAX;
		else if (qa < (QUO_BITS+1)'(CENTER_MIN)) sa = CENTER_MIN;
		else begin sa = OUT_BITS'(qa); ca = 1'b0; end
		if (qb > (QUO_BITS+1)'(CENTER_MAX))      sb = CENTER_MAX;
		else if (qb < (QUO_BITS+1)'(CENTER_MIN)) sb = CENTER_MIN;
		else begin sb = OUT_BITS'(qb); cb = 1'b0; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_c1 <= 1'b0;
		else if (en) v_c1 <= dtag[QUO_BITS].valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coll_c1 <= dtag[QUO_BITS].coll;
			clip_c1 <= ca | cb;
			ccol_c1 <= sa;
			crow_c1 <= sb;
			x1f_c1  <= dtag[QUO_BITS].x1f;
			y1f_c1  <= dtag[QUO_BITS].y1f;
		end
	end

	// ---- square stage: squared distance to the first point
	rt_tag_t            rtag [0:RAD_BITS];
	logic [SQ_BITS-1:0] rval [0:RAD_BITS];
	logic [RAD_BITS-1:0] root [0:RAD_BITS];
	logic signed [22:0] dc, dr;

	always_comb begin
		dc = 23'(ccol_c1) - 23'(x1f_c1);
		dr = 23'(crow_c1) - 23'(y1f_c1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rtag[0] <= '0;
		else if (en) rtag[0] <= '{valid: v_c1, coll: coll_c1, clip: clip_c1,
		                          ccol: ccol_c1, crow: crow_c1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rval[0]      <= SQ_BITS'(dc * dc) + SQ_BITS'(dr * dr);
			root[0]      <= '0;
		end
	end

	// chain of root cells, one result bit each
	for (genvar j = 0; j < RAD_BITS; j++) begin : g_rt
		tpcf_sqrt_cell #(.STEP(j)) u_cell (
			.clk, .arst_n, .en,
			.val_in(rval[j]), .root_in(root[j]), .tag_in(rtag[j]),
			.val_out(rval[j+1]), .root_out(root[j+1]), .tag_out(rtag[j+1])
		);
	end

	// ---- output register
	logic rsat;
	assign rsat = root[RAD_BITS][RAD_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= rtag[RAD_BITS].valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rtag[RAD_BITS].coll) begin
				center_col    <= '0;
				center_row    <= '0;
				circle_radius <= '0;
				collinear     <= 1'b1;
				clipped       <= 1'b0;
			end else begin
				center_col    <= rtag[RAD_BITS].ccol;
				center_row    <= rtag[RAD_BITS].crow;
				circle_radius <= rsat ? {OUT_BITS{1'b1}} : root[RAD_BITS][OUT_BITS-1:0];
				collinear     <= 1'b0;
				clipped       <= rtag[RAD_BITS].clip | rsat;
			end
		end
	end

	// ---- checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(circle_radius))
		else $error("stalled result changed");
	a_coll_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && collinear |-> !clipped && circle_radius == '0)
		else $error("collinear result not zero");
endmodule

// ===== bench/tb_three_point_circle_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_point_circle_fit
// self-checking bench for the circumcircle block: point triples go in with
// random idling on both channels, and each centre, radius and flag set that
// comes out is compared with an in-bench integer model of the circle fit
// ----------------------------------------------------------------------------
module tb_three_point_circle_fit import tpcf_pkg::*;;

	localparam int CB       = COORD_BITS;
	localparam int FB       = FRAC_BITS;
	localparam int LATENCY  = 80;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] col;
		logic signed [OUT_BITS-1:0] row;
		logic [OUT_BITS-1:0]        rad;
		logic                       coll;
		logic                       clip;
	} circle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CB-1:0] first_x = '0, first_y = '0, second_x = '0;
	logic [CB-1:0] second_y = '0, third_x = '0, third_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_BITS-1:0] center_col, center_row;
	logic [OUT_BITS-1:0] circle_radius;
	logic collinear, clipped;

	circle_t circles_due[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	three_point_circle_fit dut (.*);

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint clamp_ctr(longint v, ref logic clip);
		longint hi, lo;
		hi = longint'(CENTER_MAX);
		lo = longint'(CENTER_MIN);
		if (v > hi) begin
			clip = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip = 1'b1;
			return lo;
		end
		return v;
	endfunction

	// exact circumcircle in 64-bit integers
	function automatic circle_t fit_circle(longint x1, longint y1, longint x2,
			longint y2, longint x3, longint y3);
		circle_t c;
		longint ax, ay, bx, by, det, r1, s2, s3, ncol, nrow, ccol, crow, dc, dr;
		longint unsigned rad;
		logic clip;
		c = '0;
		clip = 1'b0;
		ax = x2 - x1; ay = y2 - y1;
		bx = x3 - x1; by = y3 - y1;
		det = 2 * (ax * by - bx * ay);
		if (det == 0) begin
			c.coll = 1'b1;
			return c;
		end
		r1 = x1 * x1 + y1 * y1;
		s2 = x2 * x2 + y2 * y2 - r1;
		s3 = x3 * x3 + y3 * y3 - r1;
		ncol = s2 * by - s3 * ay;
		nrow = ax * s3 - bx * s2;
		ccol = clamp_ctr((ncol * (64'sd1 <<< FB)) / det, clip);
		crow = clamp_ctr((nrow * (64'sd1 <<< FB)) / det, clip);
		dc = ccol - x1 * (64'sd1 <<< FB);
		dr = crow - y1 * (64'sd1 <<< FB);
		rad = int_sqrt(longint'(dc * dc) + longint'(dr * dr));
		if (rad > (64'd1 << OUT_BITS) - 1) begin
			rad = (64'd1 << OUT_BITS) - 1;
			clip = 1'b1;
		end
		c.col = ccol[OUT_BITS-1:0];
		c.row = crow[OUT_BITS-1:0];
		c.rad = rad[OUT_BITS-1:0];
		c.clip = clip;
		return c;
	endfunction

	// one transfer on the input channel, called at a rising edge
	task automatic send_points(int x1, int y1, int x2, int y2, int x3, int y3);
		in_valid <= 1'b1;
		first_x <= x1[CB-1:0];  first_y <= y1[CB-1:0];
		second_x <= x2[CB-1:0]; second_y <= y2[CB-1:0];
		third_x <= x3[CB-1:0];  third_y <= y3[CB-1:0];
		do @(posedge clk); while (in_stall);
		circles_due = {circles_due, fit_circle(x1[CB-1:0], y1[CB-1:0], x2[CB-1:0],
			y2[CB-1:0], x3[CB-1:0], y3[CB-1:0])};
		// each cycle the sender idles with the set chance
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_circles();
		in_valid <= 1'b0;
		@(posedge clk);
		while (circles_due.size() != 0) @(posedge clk);
	endtask

	// receiver stall pattern
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// result checker
	always @(posedge clk) begin
		circle_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{center_col, center_row, circle_radius, collinear, clipped};
			if (circles_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result col=%0d row=%0d rad=%0d",
						center_col, center_row, circle_radius);
			end else begin
				want = circles_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp col=%0d row=%0d rad=%0d coll=%b clip=%b, got col=%0d row=%0d rad=%0d coll=%b clip=%b",
							want.col, want.row, want.rad, want.coll, want.clip,
							got.col, got.row, got.rad, got.coll, got.clip);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("three_point_circle_fit test failed");
			$finish;
		end
	end

	task automatic test_corners();
		send_points(0, 0, 0, 0, 0, 0);
		send_points(2047, 2047, 2047, 2047, 2047, 2047);
		send_points(0, 0, 2047, 0, 0, 2047);
		send_points(2047, 2047, 0, 2047, 2047, 0);
		send_points(0, 2047, 2047, 0, 2047, 2047);
		send_points(0, 0, 2047, 2047, 2047, 0);
	endtask

	task automatic test_collinear();
		send_points(5, 9, 5, 9, 100, 300);
		send_points(0, 0, 1000, 1000, 2047, 2047);
		send_points(7, 0, 7, 1000, 7, 2047);
		send_points(0, 33, 2047, 33, 1024, 33);
		send_points(100, 200, 400, 800, 100, 200);
		send_points(1, 2, 3, 4, 3, 4);
	endtask

	task automatic test_saturation();
		send_points(0, 0, 2047, 1, 2046, 1);
		send_points(0, 2047, 2047, 2046, 2046, 2046);
		send_points(0, 0, 1, 2047, 1, 2046);
		send_points(2047, 0, 2046, 2047, 2046, 2046);
		send_points(0, 1024, 2047, 1025, 1024, 1024);
		send_points(10, 10, 12, 10, 10, 12);
		send_points(1000, 1000, 1001, 1000, 1000, 1001);
	endtask

	task automatic test_random_triples(int count, int s_pct, int r_pct);
		int x1, y1, x2, y2, x3, y3, k;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (count) begin
			x1 = $urandom_range(2047); y1 = $urandom_range(2047);
			x2 = $urandom_range(2047); y2 = $urandom_range(2047);
			x3 = $urandom_range(2047); y3 = $urandom_range(2047);
			case ($urandom_range(9))
				0: begin
					// small cluster
					x2 = (x1 + $urandom_range(8)) & 2047; y2 = (y1 + $urandom_range(8)) & 2047;
					x3 = (x1 + $urandom_range(8)) & 2047; y3 = (y1 + $urandom_range(8)) & 2047;
				end
				1: begin
					// exactly collinear through the midpoint
					x3 = (x1 + x2) / 2; y3 = (y1 + y2) / 2;
					if (((x1 + x2) % 2) || ((y1 + y2) % 2)) begin
						x3 = x1; y3 = y1;
					end
				end
				2: begin
					// nearly collinear, far away centre
					k = $urandom_range(1);
					x3 = (x1 + x2) / 2 + k; y3 = (y1 + y2) / 2 + (1 - k);
				end
				3: begin
					x2 = x1; y2 = y1;
				end
				default: ;
			endcase
			send_points(x1, y1, x2, y2, x3, y3);
		end
	endtask

	task automatic test_pause_until_empty();
		drain_circles();
		send_points(3, 4, 90, 17, 44, 250);
		send_points(2047, 0, 0, 2047, 1024, 1024);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 17;
		recv_idle_pct = 72;
		test_corners();
		test_collinear();
		test_saturation();
		test_random_triples(450, 17, 72);
		test_pause_until_empty();
		test_random_triples(450, 72, 17);
		test_random_triples(500, 0, 0);
		drain_circles();
		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0 && circles_due.size() == 0)
			$display("three_point_circle_fit test passed");
		else
			$display("three_point_circle_fit test failed");
		$finish;
	end
endmodule

// ===== files.f =====
sv/tpcf_pkg.sv
sv/tpcf_div_cell.sv
sv/tpcf_sqrt_cell.sv
sv/three_point_circle_fit.sv
bench/tb_three_point_circle_fit.sv
